// ===== rtl/core/lcag_pkg.sv =====
package lcag_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PRE,
        ST_ROW,
        ST_GEND,
        ST_DONE
    } state_t;

    // column of three cells: [2] row above, [1] current row, [0] row below
    typedef logic [2:0] colv_t;

    typedef struct packed {
        logic shift;
        logic first;
    } win_ctrl_t;

    localparam int unsigned CFG_W         = 7;
    localparam int unsigned GEN_W         = 10;
    localparam int unsigned BIRTH_COUNT   = 3;
    localparam int unsigned SURVIVE_COUNT = 2;

endpackage

// ===== rtl/core/lcag_ram.sv =====
module lcag_ram
    #(
        parameter int unsigned WIDTH = 1,
        parameter int unsigned DEPTH = 4096
    )
    (
        input  logic                     aclk,
        input  logic                     wr_en,
        input  logic [$clog2(DEPTH)-1:0] wr_addr,
        input  logic [WIDTH-1:0]         wr_data,
        input  logic                     rd_en,
        input  logic [$clog2(DEPTH)-1:0] rd_addr,
        output logic [WIDTH-1:0]         rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/lcag_stencil.sv =====
module lcag_stencil
    import lcag_pkg::*;
    (
        input  logic      aclk,
        input  win_ctrl_t ctl,
        input  colv_t     col_in,
        output logic      cell_next
    );

    colv_t left_reg;
    colv_t mid_reg;
    logic [3:0] count;

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            left_reg <= ctl.first ? '0 : mid_reg;
            mid_reg  <= col_in;
        end
    end

    always_comb begin
        count = 4'(left_reg[2]) + 4'(left_reg[1]) + 4'(left_reg[0])
              + 4'(mid_reg[2])  + 4'(mid_reg[0])
              + 4'(col_in[2])   + 4'(col_in[1])   + 4'(col_in[0]);
        cell_next = (count == 4'(BIRTH_COUNT))
                 || (mid_reg[1] && (count == 4'(SURVIVE_COUNT)));
    end

endmodule

// ===== rtl/core/life_cellular_automaton_grid.sv =====
// Life (B3/S23) grid engine over a MAX_ROWS x MAX_COLS one-bit cell memory with a dead
// border outside the active rows and columns. After reset a clearing pass zeroes the
// grid, one cell per cycle, while no input transaction is taken. A cell write passes through
// the DONE state and a read through the READ and DONE states before the result is registered
// on the output; DONE holds while the previous result has not been taken. Each generation of
// an advance, for nr active rows and nc active columns, runs a row-0 preload pass, then a pass
// over each active row with a flush step after its last column, then the GEND drain state.
// The grid memory has a single read port, which delivers one cell of the row below per cycle
// while a two-row line buffer supplies the old row above and the old current row.
module life_cellular_automaton_grid
    import lcag_pkg::*;
    #(
        parameter int unsigned MAX_ROWS = 64,
        parameter int unsigned MAX_COLS = 64
    )
    (
        input  logic             aclk,
        input  logic             aresetn,
        input  logic             s_valid,
        output logic             s_ready,
        input  logic [1:0]       s_op,
        input  logic [5:0]       s_row_index,
        input  logic [5:0]       s_col_index,
        input  logic             s_cell_value,
        input  logic [GEN_W-1:0] s_generation_count,
        output logic             m_valid,
        input  logic             m_ready,
        output logic             m_cell_state,
        output logic [1:0]       m_op_done,
        input  logic             cfg_valid,
        output logic             cfg_ready,
        input  logic             cfg_index,
        input  logic [CFG_W-1:0] cfg_data
    );

    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
    localparam int unsigned CW    = $clog2(MAX_COLS + 1);
    localparam int unsigned HW    = $clog2(MAX_COLS);

    state_t state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [GEN_W-1:0] gen_reg, gen_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [AW-1:0]    rbase_reg, rbase_next;
    logic [RW-1:0]    nr_reg, nr_next;
    logic [CW-1:0]    nc_reg, nc_next;
    logic [CFG_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic             pend_state_reg, pend_state_next;
    logic [1:0]       pend_op_reg, pend_op_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_cell_reg, m_cell_next;
    logic [1:0]       m_op_reg, m_op_next;

    logic             p_valid_reg, p_pre_reg, p_flush_reg, p_first_reg, p_maskd_reg;
    logic [HW-1:0]    p_hcol_reg;
    logic [AW-1:0]    p_waddr_reg;

    logic             accept;
    logic             in_grid;
    logic [AW-1:0]    cell_addr;
    logic [RW-1:0]    nr_clamp;
    logic [CW-1:0]    nc_clamp;
    logic             issue, flush;

    logic             g_wr_en, g_rd_en;
    logic [AW-1:0]    g_wr_addr, g_rd_addr;
    logic             g_wr_data, g_rd_data;
    logic             h_wr_en, h_rd_en;
    logic [HW-1:0]    h_wr_addr, h_rd_addr;
    logic [1:0]       h_wr_data, h_rd_data;

    win_ctrl_t        win_ctl;
    colv_t            win_col;
    logic             cell_new;
    logic             below;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_cell_state = m_cell_reg;
    assign m_op_done    = m_op_reg;

    assign in_grid   = (32'(s_row_index) < MAX_ROWS) && (32'(s_col_index) < MAX_COLS);
    assign cell_addr = AW'(s_row_index) * AW'(MAX_COLS) + AW'(s_col_index);
    assign nr_clamp  = (32'(rows_cfg_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_cfg_reg);
    assign nc_clamp  = (32'(cols_cfg_reg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_cfg_reg);

    assign issue = (state_reg == ST_PRE) || (state_reg == ST_ROW);
    assign flush = (col_reg == nc_reg);

    assign below   = g_rd_data && !p_maskd_reg;
    assign win_col = p_flush_reg ? '0 : {h_rd_data[1], h_rd_data[0], below};
    assign win_ctl = '{shift: p_valid_reg && !p_pre_reg, first: p_first_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= CFG_W'(64);
            cols_cfg_reg <= CFG_W'(64);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ROWS: rows_cfg_reg <= cfg_data;
                REG_COLS: cols_cfg_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            p_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        gen_reg        <= gen_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        rbase_reg      <= rbase_next;
        nr_reg         <= nr_next;
        nc_reg         <= nc_next;
        pend_state_reg <= pend_state_next;
        pend_op_reg    <= pend_op_next;
        m_cell_reg     <= m_cell_next;
        m_op_reg       <= m_op_next;
        p_pre_reg      <= (state_reg == ST_PRE);
        p_flush_reg    <= flush;
        p_first_reg    <= (col_reg == '0);
        p_maskd_reg    <= (row_reg + RW'(1) == nr_reg);
        p_hcol_reg     <= col_reg[HW-1:0];
        p_waddr_reg    <= rbase_reg + AW'(col_reg) - AW'(1);
    end

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        gen_next        = gen_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        rbase_next      = rbase_reg;
        nr_next         = nr_reg;
        nc_next         = nc_reg;
        pend_state_next = pend_state_reg;
        pend_op_next    = pend_op_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cell_next     = m_cell_reg;
        m_op_next       = m_op_reg;

        g_wr_en   = 1'b0;
        g_wr_addr = p_waddr_reg;
        g_wr_data = cell_new;
        g_rd_en   = 1'b0;
        g_rd_addr = rbase_reg + AW'(MAX_COLS) + AW'(col_reg);
        h_rd_en   = issue && !flush && (state_reg == ST_ROW);
        h_rd_addr = col_reg[HW-1:0];
        h_wr_en   = p_valid_reg && !p_flush_reg;
        h_wr_addr = p_hcol_reg;
        h_wr_data = p_pre_reg ? {1'b0, g_rd_data} : {h_rd_data[0], below};

        unique case (state_reg)
            ST_CLEAR: begin
                g_wr_en   = 1'b1;
                g_wr_addr = clr_reg;
                g_wr_data = 1'b0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    pend_op_next    = s_op;
                    pend_state_next = 1'b0;
                    state_next      = ST_DONE;
                    unique case (s_op)
                        OP_WRITE: begin
                            g_wr_en         = in_grid;
                            g_wr_addr       = cell_addr;
                            g_wr_data       = s_cell_value;
                            pend_state_next = in_grid && s_cell_value;
                        end
                        OP_READ: begin
                            g_rd_en         = 1'b1;
                            g_rd_addr       = cell_addr;
                            pend_state_next = in_grid;
                            state_next      = ST_READ;
                        end
                        OP_ADVANCE: begin
                            gen_next   = s_generation_count;
                            nr_next    = nr_clamp;
                            nc_next    = nc_clamp;
                            row_next   = '0;
                            col_next   = '0;
                            rbase_next = '0;
                            if ((s_generation_count != '0) && (nr_clamp != '0)
                                    && (nc_clamp != '0)) begin
                                state_next = ST_PRE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                pend_state_next = pend_state_reg && g_rd_data;
                state_next      = ST_DONE;
            end
            ST_PRE: begin
                g_rd_en   = !flush;
                g_rd_addr = AW'(col_reg);
                if (flush) begin
                    col_next   = '0;
                    row_next   = '0;
                    rbase_next = '0;
                    state_next = ST_ROW;
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            ST_ROW: begin
                g_rd_en = !flush;
                if (!p_pre_reg && p_valid_reg && !p_first_reg) begin
                    g_wr_en = 1'b1;
                end
                if (flush) begin
                    col_next = '0;
                    if (row_reg + RW'(1) == nr_reg) begin
                        state_next = ST_GEND;
                    end else begin
                        row_next   = row_reg + RW'(1);
                        rbase_next = rbase_reg + AW'(MAX_COLS);
                    end
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            ST_GEND: begin
                g_wr_en  = p_valid_reg && !p_pre_reg && !p_first_reg;
                col_next = '0;
                gen_next = gen_reg - GEN_W'(1);
                if (gen_reg == GEN_W'(1)) begin
                    pend_state_next = 1'b0;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_PRE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cell_next  = pend_state_reg;
                    m_op_next    = pend_op_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    lcag_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_grid (
        .aclk    (aclk),
        .wr_en   (g_wr_en),
        .wr_addr (g_wr_addr),
        .wr_data (g_wr_data),
        .rd_en   (g_rd_en),
        .rd_addr (g_rd_addr),
        .rd_data (g_rd_data)
    );

    // line buffer: [1] old row above, [0] old current row
    lcag_ram #(
        .WIDTH(2),
        .DEPTH(MAX_COLS)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data),
        .rd_en   (h_rd_en),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    lcag_stencil u_stencil (
        .aclk      (aclk),
        .ctl       (win_ctl),
        .col_in    (win_col),
        .cell_next (cell_new)
    );

endmodule
